/* rtl/core/tcprcw_pkg.sv */
// tcprcw_pkg: shared types, constants and fixed-point helpers
// for the reno congestion window block; no dependencies
package tcprcw_pkg;

  localparam int FIX_W        = 48;  // fixed-point window and threshold width
  localparam int FRAC_MAX     = 24;  // largest supported fraction width
  localparam int FRAC_DEFAULT = 16;
  localparam int ACK_W        = 32;
  localparam int SEG_W        = 16;
  localparam int BYTES_W      = 32;
  localparam int DUP_W        = 8;
  localparam int CFG_W        = 32;  // widest register
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_W        = 2 * SEG_W;  // segment size squared

  localparam logic [FIX_W-1:0] FIX_MAX      = {FIX_W{1'b1}};
  localparam logic [SEG_W-1:0] SEG_RESET    = 16'd1200;
  localparam logic [CFG_W-1:0] THRESH_RESET = 32'd10240;
  localparam logic [DUP_W-1:0] DUP_RECOVERY = 8'd3;
  localparam logic [DUP_W-1:0] DUP_MAX      = 8'd255;

  // phase codes
  localparam logic [1:0] PH_SLOW_START = 2'd0;
  localparam logic [1:0] PH_AVOID      = 2'd1;
  localparam logic [1:0] PH_RECOVERY   = 2'd2;

  // item kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESH  = 1'd1;

  typedef struct packed {
    logic             kind;
    logic [ACK_W-1:0] ack_number;
  } in_item_t;

  typedef struct packed {
    logic [BYTES_W-1:0] window_bytes;
    logic [BYTES_W-1:0] threshold_bytes;
    logic [1:0]         phase;
    logic [DUP_W-1:0]   dup_count;
    logic               ack_advanced;
    logic               retransmit_all;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_status_t;

  // byte count to fixed point, saturated to the fixed-point width
  function automatic logic [FIX_W-1:0] to_fixed(input logic [31:0] v, input int frac);
    logic [FIX_W+FRAC_MAX-1:0] wide;
    wide = {{(FIX_W+FRAC_MAX-32){1'b0}}, v} << frac;
    if (|wide[FIX_W+FRAC_MAX-1:FIX_W]) begin
      to_fixed = FIX_MAX;
    end else begin
      to_fixed = wide[FIX_W-1:0];
    end
  endfunction

  // integer part, saturated to the byte field width
  function automatic logic [BYTES_W-1:0] bytes_out(input logic [FIX_W-1:0] f,
                                                   input int frac);
    logic [FIX_W-1:0] b;
    b = f >> frac;
    if (|b[FIX_W-1:BYTES_W]) begin
      bytes_out = {BYTES_W{1'b1}};
    end else begin
      bytes_out = b[BYTES_W-1:0];
    end
  endfunction

  function automatic logic [FIX_W-1:0] sat_add(input logic [FIX_W-1:0] a,
                                               input logic [FIX_W-1:0] b);
    logic [FIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[FIX_W] ? FIX_MAX : s[FIX_W-1:0];
  endfunction

endpackage

/* rtl/core/tcprcw_div.sv */
// tcprcw_div: bit-serial restoring divider for the avoidance increment
// depends on tcprcw_pkg
module tcprcw_div import tcprcw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [FIX_W-1:0] denom,
  output logic             done,
  output logic [FIX_W-1:0] quot
);

  localparam int STEPS = NUM_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] numer_sh;
  logic [FIX_W-1:0] rem;
  logic [FIX_W-1:0] q;
  logic             sat;

  logic [FIX_W:0] rem_sh;
  logic [FIX_W:0] rem_diff;
  logic           fits;

  assign rem_sh   = {rem, numer_sh[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, denom};
  assign rem_diff = rem_sh - {1'b0, denom};
  assign quot     = sat ? FIX_MAX : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numer_sh <= numer;
      rem      <= '0;
      q        <= '0;
      sat      <= (denom == '0);  // zero window: saturate the increment
    end else if (cnt != '0) begin
      numer_sh <= {numer_sh[NUM_W-2:0], 1'b0};
      rem      <= fits ? rem_diff[FIX_W-1:0] : rem_sh[FIX_W-1:0];
      q        <= {q[FIX_W-2:0], fits};
      sat      <= sat | q[FIX_W-1];  // quotient outgrew the window width
    end
  end

endmodule

/* rtl/core/tcprcw_dp.sv */
// tcprcw_dp: window state, configuration registers and step datapath
// depends on tcprcw_pkg and tcprcw_div
module tcprcw_dp import tcprcw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output out_item_t            out_item
);

  logic [SEG_W-1:0] segment_size;
  logic [NUM_W-1:0] square;
  logic [FIX_W-1:0] window;
  logic [FIX_W-1:0] threshold;
  logic [1:0]       phase;
  logic [ACK_W-1:0] last_ack;
  logic [DUP_W-1:0] dup;
  logic             item_kind;
  logic [ACK_W-1:0] item_ack;

  logic [FIX_W-1:0] window_next;
  logic [FIX_W-1:0] threshold_next;
  logic [1:0]       phase_next;
  logic [ACK_W-1:0] last_ack_next;
  logic [DUP_W-1:0] dup_next;
  logic             advanced;
  logic             retransmit;

  logic [FIX_W-1:0] seg_fix;
  logic [FIX_W-1:0] seg3_fix;
  logic [FIX_W-1:0] div_q;
  logic [FIX_W-1:0] inc;
  logic [FIX_W-1:0] win_add;
  logic [FIX_W-1:0] win_a;
  logic [DUP_W-1:0] dup_a;
  logic             newer;
  logic             same;
  logic             div_done;

  assign seg_fix  = to_fixed({{(32-SEG_W){1'b0}}, segment_size}, FRAC_BITS);
  assign seg3_fix = to_fixed({{(32-SEG_W-2){1'b0}},
                              {2'b00, segment_size} + {1'b0, segment_size, 1'b0}},
                             FRAC_BITS);

  assign newer = item_ack > last_ack;
  assign same  = item_ack == last_ack;

  assign status.need_div = (item_kind == KIND_ACK) && newer && (phase == PH_AVOID);
  assign status.div_done = div_done;

  tcprcw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (square),
    .denom (window),
    .done  (div_done),
    .quot  (div_q)
  );

  // one shared adder: avoidance adds the quotient, everything else one segment
  assign inc     = (phase == PH_AVOID) ? div_q : seg_fix;
  assign win_add = sat_add(window, inc);

  always_comb begin
    window_next    = window;
    threshold_next = threshold;
    phase_next     = phase;
    last_ack_next  = last_ack;
    dup_next       = dup;
    advanced       = 1'b0;
    retransmit     = 1'b0;
    win_a          = window;
    dup_a          = dup;
    if (item_kind == KIND_TIMEOUT) begin
      threshold_next = {1'b0, window[FIX_W-1:1]};
      window_next    = seg_fix;
      dup_next       = '0;
      phase_next     = PH_SLOW_START;
      retransmit     = 1'b1;
    end else if (phase == PH_SLOW_START || phase == PH_AVOID) begin
      advanced = newer;
      if (newer) begin
        win_a         = win_add;
        dup_a         = '0;
        last_ack_next = item_ack;
      end else if (same && dup != DUP_MAX) begin
        dup_a = dup + DUP_W'(1);
      end
      window_next = win_a;
      dup_next    = dup_a;
      // third duplicate: only reached without a window step
      if (dup_a == DUP_RECOVERY) begin
        threshold_next = {1'b0, window[FIX_W-1:1]};
        window_next    = sat_add({1'b0, window[FIX_W-1:1]}, seg3_fix);
        phase_next     = PH_RECOVERY;
      end else if (phase == PH_SLOW_START && win_a >= threshold) begin
        phase_next = PH_AVOID;
      end
    end else begin
      // fast recovery, and the unused phase code
      advanced = newer;
      if (newer) begin
        window_next   = threshold;
        dup_next      = '0;
        phase_next    = PH_AVOID;
        last_ack_next = item_ack;
      end else if (same) begin
        window_next = win_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size <= SEG_RESET;
      window       <= to_fixed({{(32-SEG_W){1'b0}}, SEG_RESET}, FRAC_BITS);
      threshold    <= to_fixed(THRESH_RESET, FRAC_BITS);
      phase        <= PH_SLOW_START;
      last_ack     <= '0;
      dup          <= '0;
    end else if (cmd.commit) begin
      window    <= window_next;
      threshold <= threshold_next;
      phase     <= phase_next;
      last_ack  <= last_ack_next;
      dup       <= dup_next;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEGMENT_SIZE: segment_size <= cfg_data[SEG_W-1:0];
        REG_INIT_THRESH:  threshold    <= to_fixed(cfg_data, FRAC_BITS);
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    square <= {{SEG_W{1'b0}}, segment_size} * {{SEG_W{1'b0}}, segment_size};
    if (cmd.load_item) begin
      item_kind <= in_item.kind;
      item_ack  <= in_item.ack_number;
    end
    if (cmd.commit) begin
      out_item.window_bytes    <= bytes_out(window_next, FRAC_BITS);
      out_item.threshold_bytes <= bytes_out(threshold_next, FRAC_BITS);
      out_item.phase           <= phase_next;
      out_item.dup_count       <= dup_next;
      out_item.ack_advanced    <= advanced;
      out_item.retransmit_all  <= retransmit;
    end
  end

endmodule

/* rtl/core/tcprcw_ctrl.sv */
// tcprcw_ctrl: sequencing state machine and output handshake
// depends on tcprcw_pkg
module tcprcw_ctrl import tcprcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_COMMIT;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/tcp_reno_congestion_window.sv */
// tcp_reno_congestion_window: top level of the reno congestion window block
// depends on tcprcw_pkg, tcprcw_ctrl, tcprcw_dp (which holds tcprcw_div)
//
// Reno-style congestion window control. Each input item is an acknowledgement
// (kind 0, with its byte sequence number) or a receive timeout (kind 1), and
// each one yields exactly one result item with the window, threshold, phase
// and duplicate count after the step. One item is worked on at a time. An
// item passes through the steps accept, evaluate and commit. A new
// acknowledgement in congestion avoidance also passes through a divide step
// between evaluate and commit, because the mss*mss/cwnd increment comes from
// a bit-serial restoring divider that resolves one quotient bit per cycle;
// the controller moves on to commit once the divider raises its done flag.
// The result sits in an output register, so the next item is accepted while
// a finished result still waits to be taken; that next item then waits in
// its commit step until the register frees. Configuration writes (segment
// size at index 0, initial threshold at index 1, which also reloads the
// threshold at once) are meant for idle periods only. There is no clearing
// pass after reset; the block takes items from the first cycle after reset.
module tcp_reno_congestion_window import tcprcw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEFAULT  // fraction bits, 8 to 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;     // load item, start divide, commit step
  dp_status_t status;  // divide needed, divide finished

  tcprcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // state registers, step logic, divider and result register
  tcprcw_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule

/* tb/sv/tcp_reno_congestion_window_tb.sv */
// tcp_reno_congestion_window_tb: self-checking bench for the reno congestion window block
// uses tcprcw_pkg types and constants; tracks window state alongside the block and
// compares every result item field by field
module tcp_reno_congestion_window_tb;
  import tcprcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // bench tracker: window, threshold, phase and duplicate count as the block should
  // hold them, plus the queue of result items still owed by the block
  class cwnd_tracker;
    localparam int FRAC = FRAC_DEFAULT;

    logic [SEG_W-1:0] seg_size;
    logic [CFG_W-1:0] init_thresh;
    logic [1:0]       phase;
    logic [FIX_W-1:0] cwnd;
    logic [FIX_W-1:0] ssthresh;
    logic [ACK_W-1:0] last_ack;
    logic [DUP_W-1:0] dups;
    out_item_t        owed_reports[$];
    int               errors;

    function new();
      seg_size    = SEG_RESET;
      init_thresh = THRESH_RESET;
      phase       = PH_SLOW_START;
      cwnd        = fixed_of(64'(seg_size));
      ssthresh    = fixed_of(64'(init_thresh));
      last_ack    = '0;
      dups        = '0;
      errors      = 0;
    endfunction

    function logic [FIX_W-1:0] fixed_of(logic [63:0] v);
      logic [127:0] w;
      w = 128'(v) << FRAC;
      return (w > 128'(FIX_MAX)) ? FIX_MAX : w[FIX_W-1:0];
    endfunction

    function logic [FIX_W-1:0] grow(logic [FIX_W-1:0] a, logic [FIX_W-1:0] b);
      logic [FIX_W:0] s;
      s = (FIX_W+1)'(a) + (FIX_W+1)'(b);
      return (s > (FIX_W+1)'(FIX_MAX)) ? FIX_MAX : s[FIX_W-1:0];
    endfunction

    // mss*mss/cwnd in fixed point, truncated; a zero window gives all ones
    function logic [FIX_W-1:0] avoid_step(logic [SEG_W-1:0] mss, logic [FIX_W-1:0] win);
      logic [31:0]  sq;
      logic [127:0] q;
      if (win == '0) return FIX_MAX;
      sq = 32'(mss) * 32'(mss);
      q  = (128'(sq) << (2 * FRAC)) / 128'(win);
      return (q > 128'(FIX_MAX)) ? FIX_MAX : q[FIX_W-1:0];
    endfunction

    function logic [BYTES_W-1:0] bytes_of(logic [FIX_W-1:0] f);
      logic [FIX_W-1:0] b;
      b = f >> FRAC;
      return (b > FIX_W'(32'hFFFF_FFFF)) ? {BYTES_W{1'b1}} : b[BYTES_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SEGMENT_SIZE: seg_size = data[SEG_W-1:0];
        REG_INIT_THRESH: begin
          init_thresh = data;
          ssthresh    = fixed_of(64'(data));  // threshold reloads at once
        end
        default: ;
      endcase
    endfunction

    // advance the window state by one accepted item and queue the owed result
    function void take_item(in_item_t it);
      out_item_t        r;
      logic [FIX_W-1:0] seg_fx;
      logic             newer;
      logic             same;
      r      = '0;
      seg_fx = fixed_of(64'(seg_size));
      if (it.kind == KIND_TIMEOUT) begin
        ssthresh         = cwnd >> 1;
        cwnd             = seg_fx;
        dups             = '0;
        phase            = PH_SLOW_START;
        r.retransmit_all = 1'b1;
      end else begin
        newer          = it.ack_number > last_ack;
        same           = it.ack_number == last_ack;
        r.ack_advanced = newer;
        if (phase == PH_SLOW_START || phase == PH_AVOID) begin
          if (newer) begin
            if (phase == PH_SLOW_START) cwnd = grow(cwnd, seg_fx);
            else cwnd = grow(cwnd, avoid_step(seg_size, cwnd));
            dups     = '0;
            last_ack = it.ack_number;
          end else if (same && dups != DUP_MAX) begin
            dups++;
          end
          // third duplicate wins over the slow start exit check
          if (dups == DUP_RECOVERY) begin
            ssthresh = cwnd >> 1;
            cwnd     = grow(ssthresh, fixed_of(64'(3 * 32'(seg_size))));
            phase    = PH_RECOVERY;
          end else if (phase == PH_SLOW_START && cwnd >= ssthresh) begin
            phase = PH_AVOID;
          end
        end else begin
          if (newer) begin
            cwnd     = ssthresh;
            dups     = '0;
            phase    = PH_AVOID;
            last_ack = it.ack_number;
          end else if (same) begin
            cwnd = grow(cwnd, seg_fx);
          end
        end
      end
      r.window_bytes    = bytes_of(cwnd);
      r.threshold_bytes = bytes_of(ssthresh);
      r.phase           = phase;
      r.dup_count       = dups;
      owed_reports.push_back(r);
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void match_report(out_item_t got);
      out_item_t want;
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, got window %0d",
                 $time, got.window_bytes);
        return;
      end
      want = owed_reports.pop_front();
      check_field("window_bytes", want.window_bytes, got.window_bytes);
      check_field("threshold_bytes", want.threshold_bytes, got.threshold_bytes);
      check_field("phase", 32'(want.phase), 32'(got.phase));
      check_field("dup_count", 32'(want.dup_count), 32'(got.dup_count));
      check_field("ack_advanced", 32'(want.ack_advanced), 32'(got.ack_advanced));
      check_field("retransmit_all", 32'(want.retransmit_all), 32'(got.retransmit_all));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cwnd_tracker trk;

  // idle percentages per side, switched by the main sequence
  int send_idle_pct;
  int recv_idle_pct;
  // long receiver hold-off: requested by the main sequence, counted by the receiver
  bit stall_request;
  int stall_left;

  tcp_reno_congestion_window dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver side: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_left    = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor: every taken result is matched against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      trk.match_report(out_item);
    end
  end

  function automatic in_item_t item_of(logic k, logic [ACK_W-1:0] n);
    in_item_t it;
    it.kind       = k;
    it.ack_number = n;
    return it;
  endfunction

  // offer one item and hold it until taken; valid stays high on return so the
  // next call can present its item in the same step without a low cycle
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trk.take_item(it);
  endtask

  task automatic send_ack(input logic [ACK_W-1:0] n);
    send_item(item_of(KIND_ACK, n));
  endtask

  task automatic send_timeout(input logic [ACK_W-1:0] n);
    send_item(item_of(KIND_TIMEOUT, n));
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.pending() != 0) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic program_regs(input logic [SEG_W-1:0] seg, input logic [CFG_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEGMENT_SIZE;
    cfg_data  <= CFG_W'(seg);
    @(posedge clk);
    cfg_index <= REG_INIT_THRESH;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.write_reg(REG_SEGMENT_SIZE, CFG_W'(seg));
    trk.write_reg(REG_INIT_THRESH, thr);
  endtask

  // mostly well-formed ack streams: advancing acks, duplicate bursts that reach
  // fast recovery, stale acks and occasional timeouts with random ack fields
  task automatic random_traffic(input int count);
    int i;
    int sel;
    int burst;
    i = 0;
    while (i < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 7) begin
        send_timeout($urandom());
        i++;
      end else if (sel < 55) begin
        if (trk.last_ack > 32'hFFF0_0000) send_ack(trk.last_ack);
        else send_ack(trk.last_ack + $urandom_range(1, 3000));
        i++;
      end else if (sel < 87) begin
        burst = $urandom_range(1, 5);
        repeat (burst) send_ack(trk.last_ack);
        i += burst;
      end else begin
        // stale or equal ack
        send_ack($urandom_range(0, trk.last_ack));
        i++;
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    in_item       <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_SEGMENT_SIZE;
    cfg_data      <= '0;
    send_idle_pct = 25;
    recv_idle_pct = 56;
    stall_request = 1'b0;
    stall_left    = 0;
    trk           = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed walk at the reset settings (1200 byte segments, 10240 threshold)
    send_ack(32'd0);                       // equal to the reset ack: duplicate
    send_ack(32'd0);
    send_ack(32'd1000);                    // first new ack in slow start
    for (int k = 2; k <= 8; k++) begin
      send_ack(32'(k * 1000));             // grows past threshold into avoidance
    end
    send_ack(32'd9000);                    // avoidance step through the divider
    repeat (3) send_ack(32'd9000);         // third duplicate enters fast recovery
    send_ack(32'd9000);                    // further duplicate inflates the window
    send_ack(32'd500);                     // stale ack during recovery
    send_ack(32'd12000);                   // new ack deflates and leaves recovery
    send_ack(32'd11000);                   // stale ack in avoidance
    send_timeout(32'hFFFF_FFFF);           // timeout, ack field ignored
    send_timeout(32'd0);                   // back-to-back timeout halves again
    send_ack(32'd13000);
    send_ack(32'd13000);
    send_ack(32'd0);                       // stale ack in avoidance
    random_traffic(110);

    // zero segment size and zero threshold: window collapses to zero, then the
    // avoidance divide by a zero window saturates it
    drain();
    program_regs('0, '0);
    random_traffic(40);
    send_timeout(32'h5A5A_A5A5);
    send_ack(trk.last_ack + 32'd10);
    send_timeout(32'hA5A5_5A5A);           // threshold now zero as well
    send_ack(trk.last_ack + 32'd10);       // slow start exits at once
    send_ack(trk.last_ack + 32'd10);       // zero window divide
    send_ack(trk.last_ack + 32'd10);

    // largest segment and threshold, starting from a saturated window
    drain();
    program_regs({SEG_W{1'b1}}, {CFG_W{1'b1}});
    send_ack(trk.last_ack + 32'd1);        // saturating add
    repeat (4) send_ack(trk.last_ack);     // recovery from a saturated window
    random_traffic(120);

    // other way round: sender idles more than the receiver
    drain();
    send_idle_pct = 56;
    recv_idle_pct = 25;
    program_regs(16'd1, '0);
    random_traffic(30);
    stall_request = 1'b1;                  // receiver holds off, block backs up
    random_traffic(70);

    drain();
    program_regs(16'($urandom_range(200, 1500)), 32'($urandom_range(400, 45000)));
    random_traffic(60);
    drain();                               // sender pause until all results are in
    random_traffic(60);

    // neither side idles
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'($urandom_range(1, 65535)), $urandom_range(0, 32'h00FF_FFFF));
    random_traffic(120);
    drain();
    program_regs(16'd1460, 32'd65535);
    random_traffic(120);
    send_ack(32'hFFFF_FFFF);               // largest ack number
    repeat (3) send_ack(32'hFFFF_FFFF);
    send_ack(32'd0);
    send_timeout(32'd0);

    drain();
    repeat (80) @(posedge clk);
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* tcp_reno_congestion_window.f */
rtl/core/tcprcw_pkg.sv
rtl/core/tcprcw_div.sv
rtl/core/tcprcw_dp.sv
rtl/core/tcprcw_ctrl.sv
rtl/core/tcp_reno_congestion_window.sv
tb/sv/tcp_reno_congestion_window_tb.sv
